>>> hw/rtl/fwrk_pkg.sv
// Package for the FIFO with remove-by-key: sizes, operation and status codes,
// and the control bundle broadcast to every storage cell.
// No dependencies.
`timescale 1ns / 1ps

package fwrk_pkg;

	localparam int DEPTH      = 16;
	localparam int TOKEN_BITS = 16;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 5;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [1:0] OP_ENQ = 2'd0;
	localparam logic [1:0] OP_DEQ = 2'd1;
	localparam logic [1:0] OP_REM = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

	typedef struct packed {
		logic                  enq_ok;
		logic                  deq_ok;
		logic                  rem_req;
		logic [TOKEN_BITS-1:0] key;
		logic [CNT_W-1:0]      count;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/fwrk_cell.sv
// One storage cell of the queue chain: holds one token, compares it with the
// search key and takes its right neighbor's token when the queue closes up.
// Depends on fwrk_pkg.
`timescale 1ns / 1ps

module fwrk_cell import fwrk_pkg::*; (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [CNT_W-1:0]      idx,
	input  logic [TOKEN_BITS-1:0] next_tok,
	input  logic                  hit_in,
	output logic                  hit_out,
	output logic [TOKEN_BITS-1:0] tok
);

	logic [TOKEN_BITS-1:0] tok_q;
	logic                  occupied;
	logic                  match;
	logic                  shift;
	logic                  load;

	assign occupied = idx < ctrl.count;
	assign match    = occupied && (tok_q == ctrl.key);
	// The hit flag ripples toward the rear, so only the oldest match and the
	// cells behind it see it set.
	assign hit_out  = hit_in | match;
	assign shift    = (ctrl.deq_ok && occupied) || (ctrl.rem_req && hit_out);
	assign load     = ctrl.enq_ok && (idx == ctrl.count);
	assign tok      = tok_q;

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q <= ctrl.key;
		end else if (shift) begin
			tok_q <= next_tok;
		end
	end

endmodule

>>> hw/rtl/fifo_with_remove_by_key.sv
// Top level of the FIFO with remove-by-key: chain of storage cells, entry
// count, capacity register on an APB port and a registered result stage.
// Depends on fwrk_pkg and fwrk_cell.
// The result of a request is registered and presented in the cycle after it is taken.
// Throughput: one request per cycle unless out_ready stalls; the match flag
// ripples through all cells in the same cycle, and the next request sees the
// updated chain. Reset clears the entry count, the result valid flag and sets
// capacity to 16; the cell tokens are not reset.
`timescale 1ns / 1ps

module fifo_with_remove_by_key import fwrk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic [TOKEN_BITS-1:0] token,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [TOKEN_BITS-1:0] token_out,
	output logic [CNT_W-1:0]      entry_count,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	logic [CAP_W-1:0]      capacity_q;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [TOKEN_BITS-1:0] token_out_q;
	logic [CNT_W-1:0]      entry_count_q;

	logic                  take;
	logic [CNT_W-1:0]      limit;
	logic                  found;
	logic [1:0]            status_d;
	logic [TOKEN_BITS-1:0] token_out_d;
	logic [CNT_W-1:0]      count_d;
	cell_ctrl_t            ctrl;
	logic [DEPTH:0]        hit;
	logic [TOKEN_BITS-1:0] tok [DEPTH];

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[PADDR_W-1:2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign limit    = (int'(capacity_q) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(capacity_q);
	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		ctrl.enq_ok  = take && (operation == OP_ENQ) && (count_q < limit);
		ctrl.deq_ok  = take && (operation == OP_DEQ) && (count_q != '0);
		ctrl.rem_req = take && (operation == OP_REM);
		ctrl.key     = token;
		ctrl.count   = count_q;
	end

	assign hit[0] = 1'b0;
	assign found  = hit[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		fwrk_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.idx      (CNT_W'(i)),
			.next_tok ((i + 1 < DEPTH) ? tok[(i + 1) % DEPTH] : tok[i]),
			.hit_in   (hit[i]),
			.hit_out  (hit[i+1]),
			.tok      (tok[i])
		);
	end

	always_comb begin
		status_d    = ST_OK;
		token_out_d = '0;
		count_d     = count_q;
		case (operation)
			OP_ENQ: begin
				if (ctrl.enq_ok) begin
					count_d = count_q + CNT_W'(1);
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_DEQ: begin
				if (ctrl.deq_ok) begin
					token_out_d = tok[0];
					count_d     = count_q - CNT_W'(1);
				end else begin
					status_d = ST_EMPTY;
				end
			end
			OP_REM: begin
				if (found) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q      <= status_d;
			token_out_q   <= token_out_d;
			entry_count_q <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign token_out   = token_out_q;
	assign entry_count = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= DEPTH)
		else $error("entry count exceeds queue depth");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("request refused with result stage empty");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq_ok |=> (count_q == $past(count_q) + CNT_W'(1)) && (status_q == ST_OK))
		else $error("accepted enqueue did not raise the count");

	a_deq_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (operation == OP_DEQ) && (count_q == '0))
		|=> (status_q == ST_EMPTY) && (token_out_q == '0) && (count_q == '0))
		else $error("dequeue on empty queue changed state or reported a token");

	a_rem_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.rem_req && !found) |=> $stable(count_q) && (status_q == ST_NOT_FOUND))
		else $error("missed removal changed the count");

endmodule

>>> tb/tb_fifo_with_remove_by_key.sv
// Self-checking testbench for the FIFO with remove-by-key: directed and random
// requests under varied handshake stalls, checked against a queue-based predictor.
// Depends on fwrk_pkg and fifo_with_remove_by_key.
`timescale 1ns / 1ps

module tb_fifo_with_remove_by_key;
	import fwrk_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]            status;
		logic [TOKEN_BITS-1:0] token_out;
		logic [CNT_W-1:0]      entry_count;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] operation;
	logic [TOKEN_BITS-1:0] token;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [TOKEN_BITS-1:0] token_out;
	logic [CNT_W-1:0] entry_count;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	logic [TOKEN_BITS-1:0] queued_tokens[$];
	logic [CAP_W-1:0] capacity_setting;
	result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int cycles = 0;

	fifo_with_remove_by_key dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.token(token),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.token_out(token_out),
		.entry_count(entry_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Applies one request to the shadow queue and returns the result it must produce.
	function automatic result_t apply_request(input logic [1:0] op,
			input logic [TOKEN_BITS-1:0] tok);
		result_t r;
		int limit;
		int hit;
		r.status = ST_OK;
		r.token_out = '0;
		limit = (capacity_setting > DEPTH) ? DEPTH : int'(capacity_setting);
		hit = -1;
		case (op)
			OP_ENQ: begin
				if (queued_tokens.size() >= limit)
					r.status = ST_FULL;
				else
					queued_tokens.push_back(tok);
			end
			OP_DEQ: begin
				if (queued_tokens.size() == 0)
					r.status = ST_EMPTY;
				else
					r.token_out = queued_tokens.pop_front();
			end
			OP_REM: begin
				for (int i = 0; i < queued_tokens.size(); i++) begin
					if (hit < 0 && queued_tokens[i] == tok)
						hit = i;
				end
				if (hit < 0)
					r.status = ST_NOT_FOUND;
				else
					queued_tokens.delete(hit);
			end
			default: ;
		endcase
		r.entry_count = CNT_W'(queued_tokens.size());
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		got = {status, token_out, entry_count};
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d token %h count %0d",
					$time, got.status, got.token_out, got.entry_count);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got !== want) begin
					$display("%0t: expected status %0d token %h count %0d, got status %0d token %h count %0d",
						$time, want.status, want.token_out, want.entry_count,
						got.status, got.token_out, got.entry_count);
					mismatches++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_request(input logic [1:0] op, input logic [TOKEN_BITS-1:0] tok);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		token <= tok;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(apply_request(op, tok));
		requests_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes the capacity register, then reads it back.
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		logic [PDATA_W-1:0] readback;
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		capacity_setting = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== PDATA_W'(value)) begin
			$display("%0t: capacity readback expected %0d, got %0d", $time, value, readback);
			mismatches++;
		end
	endtask

	// Removal keys mostly name a token that is queued, so that removals hit.
	function automatic logic [TOKEN_BITS-1:0] choose_token(input logic [1:0] op);
		if (op == OP_REM && queued_tokens.size() > 0 && $urandom_range(3) != 0)
			return queued_tokens[$urandom_range(queued_tokens.size() - 1)];
		if ($urandom_range(1) == 0)
			return TOKEN_BITS'($urandom_range(7));
		return TOKEN_BITS'($urandom_range(16'hFFFF));
	endfunction

	task automatic test_empty_queue();
		write_capacity(CAP_W'(16));
		send_request(OP_DEQ, 16'h0000);
		send_request(OP_REM, 16'h0000);
		send_request(OP_NOP, 16'hFFFF);
		wait_idle();
	endtask

	task automatic test_order_and_removal();
		send_request(OP_ENQ, 16'h0000);
		send_request(OP_ENQ, 16'hFFFF);
		send_request(OP_ENQ, 16'h5555);
		send_request(OP_ENQ, 16'hAAAA);
		send_request(OP_ENQ, 16'h5555);
		send_request(OP_NOP, 16'h1234);
		// The oldest of the two equal tokens goes; the later copy stays at the rear.
		send_request(OP_REM, 16'h5555);
		send_request(OP_REM, 16'h1234);
		send_request(OP_REM, 16'h5555);
		send_request(OP_REM, 16'h0000);
		send_request(OP_DEQ, 16'h0000);
		send_request(OP_DEQ, 16'hFFFF);
		send_request(OP_DEQ, 16'h0000);
		wait_idle();
	endtask

	task automatic test_capacity_limits();
		write_capacity(CAP_W'(0));
		send_request(OP_ENQ, 16'h1111);
		send_request(OP_DEQ, 16'h0000);
		write_capacity(CAP_W'(1));
		send_request(OP_ENQ, 16'h2222);
		send_request(OP_ENQ, 16'h3333);
		send_request(OP_REM, 16'h2222);
		wait_idle();
	endtask

	task automatic test_random(input int n, input int cap, input int send_pct,
			input int stall_pct);
		logic [1:0] op;
		int pick;
		bit filling;
		write_capacity(CAP_W'(cap));
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		filling = 1'b1;
		repeat (n) begin
			if ($urandom_range(31) == 0)
				filling = !filling;
			pick = $urandom_range(99);
			if (pick < 4)
				op = OP_NOP;
			else if (pick < (filling ? 70 : 24))
				op = OP_ENQ;
			else if (pick < (filling ? 82 : 64))
				op = OP_DEQ;
			else
				op = OP_REM;
			send_request(op, choose_token(op));
		end
		wait_idle();
	endtask

	// Short bursts, each followed by a pause until every result is back.
	task automatic test_burst_drain(input int n);
		int burst;
		logic [1:0] op;
		write_capacity(CAP_W'(16));
		send_idle_pct = 0;
		recv_stall_pct = 46;
		while (n > 0) begin
			burst = $urandom_range(12, 1);
			repeat (burst) begin
				op = 2'($urandom_range(3));
				send_request(op, choose_token(op));
			end
			n -= burst;
			wait_idle();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_ENQ;
		token <= '0;
		out_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		capacity_setting = CAP_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_order_and_removal();
		test_capacity_limits();
		test_random(150, 16, 0, 0);
		test_random(130, 31, 46, 0);
		test_random(110, 1, 0, 46);
		test_random(50, 0, 35, 35);
		test_random(130, $urandom_range(15, 2), 35, 35);
		test_random(130, $urandom_range(31), 46, 46);
		test_burst_drain(130);

		wait_idle();
		repeat (4) @(posedge clk);
		$display("Checked %0d results from %0d requests at capacities 0, 1, 16, 31 and random,",
			results_checked, requests_sent);
		$display("with enqueue, dequeue, keyed removal and the unused code under varied stalls.");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/fwrk_pkg.sv
hw/rtl/fwrk_cell.sv
hw/rtl/fifo_with_remove_by_key.sv
tb/tb_fifo_with_remove_by_key.sv
